@@ sv/lpfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfr_pkg: shared types and constants for the page LCD frame store
// Operation codes, panel command bytes and the command word that the front
// end hands to the execution unit through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

    // Geometry defaults (pixel column and row fields are 7 and 6 bits wide)
    localparam int COLUMNS_DEFAULT = 128;
    localparam int PAGES_DEFAULT   = 8;
    localparam int ROWS_PER_PAGE   = 8;

    // Depth of the queue between front end and execution unit
    localparam int QUEUE_DEPTH = 2;

    // Panel command bytes
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [7:0] CMD_COL_LOW  = 8'h00;
    localparam logic [3:0] NIBBLE_MASK  = 4'hF;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_PIXEL   = 2'd0,
        OP_FILL    = 2'd1,
        OP_REFRESH = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    // Position inside one page of a refresh
    typedef enum logic [1:0] {
        PH_PAGE     = 2'd0,
        PH_COL_HIGH = 2'd1,
        PH_COL_LOW  = 2'd2,
        PH_DATA     = 2'd3
    } phase_t;

    // Classified command word
    typedef struct packed {
        op_t        op;
        logic [6:0] col;       // pixel column or first refresh column
        logic [2:0] page;      // pixel page or first refresh page
        logic [2:0] bit_sel;   // row inside the page
        logic       pixel_on;
        logic       hit;       // pixel lies inside the store
        logic [7:0] fill;
        logic [2:0] end_page;  // last refresh page, limited to the store
        logic [6:0] end_col;   // last refresh column, limited to the store
        logic       area_ok;   // refresh page range is not empty
    } cmd_t;

endpackage

`default_nettype wire

@@ sv/lpfr_front.sv @@
// ----------------------------------------------------------------------------
// lpfr_front: input word decode and classification
// Unpacks the stream word, range-checks pixel writes, limits the refresh
// area to the store and builds the command word pushed into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_front #(
    parameter int COLUMNS = lpfr_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = lpfr_pkg::PAGES_DEFAULT
) (
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [39:0]    s_tdata,
    input  wire logic [1:0]     s_tuser,
    input  wire logic           queue_full,
    input  wire logic           init_busy,
    output logic                push,
    output lpfr_pkg::cmd_t      push_cmd
);

    logic [6:0] x_f;
    logic [5:0] y_f;
    logic [6:0] xe_f;
    logic [5:0] ye_f;
    logic [2:0] p0;
    logic [2:0] p1_raw;
    logic [2:0] p1;
    logic [6:0] xe_lim;

    assign x_f  = s_tdata[6:0];
    assign y_f  = s_tdata[12:7];
    assign xe_f = s_tdata[28:22];
    assign ye_f = s_tdata[34:29];

    // Take a word only when the queue has room and no clearing or fill sweep is running
    assign s_tready = !queue_full && !init_busy;
    assign push     = s_tvalid && s_tready;

    // Page numbers and area limits
    assign p0     = y_f[5:3];
    assign p1_raw = ye_f[5:3];
    assign p1     = (int'(p1_raw) >= PAGES) ? 3'(PAGES - 1) : p1_raw;
    assign xe_lim = (int'(xe_f) >= COLUMNS) ? 7'(COLUMNS - 1) : xe_f;

    // Command word
    always_comb begin
        push_cmd          = '0;
        push_cmd.op       = lpfr_pkg::op_t'(s_tuser);
        push_cmd.col      = x_f;
        push_cmd.page     = p0;
        push_cmd.bit_sel  = y_f[2:0];
        push_cmd.pixel_on = s_tdata[13];
        push_cmd.hit      = (int'(x_f) < COLUMNS) && (int'(p0) < PAGES);
        push_cmd.fill     = s_tdata[21:14];
        push_cmd.end_page = p1;
        push_cmd.end_col  = xe_lim;
        push_cmd.area_ok  = (int'(p0) < PAGES) && (p1 >= p0);
    end

endmodule

`default_nettype wire

@@ sv/lpfr_queue.sv @@
// ----------------------------------------------------------------------------
// lpfr_queue: short command queue
// Register FIFO that decouples the front end from the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire lpfr_pkg::cmd_t push_cmd,
    output logic                full,
    output logic                head_valid,
    output lpfr_pkg::cmd_t      head_cmd,
    input  wire logic           pop
);

    localparam int PTR_W = (lpfr_pkg::QUEUE_DEPTH > 1) ? $clog2(lpfr_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lpfr_pkg::QUEUE_DEPTH + 1);

    lpfr_pkg::cmd_t entry_reg [lpfr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(lpfr_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lpfr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lpfr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/lpfr_back.sv @@
// ----------------------------------------------------------------------------
// lpfr_back: frame store and refresh sequencer
// Owns the frame store memory, runs the clearing and fill sweeps, the pixel
// read-modify-write and the per-page command/data byte sequence, and holds
// the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_back #(
    parameter int COLUMNS = lpfr_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = lpfr_pkg::PAGES_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           head_valid,
    input  wire lpfr_pkg::cmd_t head_cmd,
    output logic                pop,
    output logic                init_busy,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_SWEEP = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RMW   = 4'b0100,
        ST_DATA  = 4'b1000
    } state_t;

    // Frame store
    logic [7:0] mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        rd_data_reg;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [7:0]        sweep_val_reg, sweep_val_next;
    logic [ADDR_W-1:0] pix_addr_reg, pix_addr_next;
    logic [7:0]        pix_mask_reg, pix_mask_next;
    logic              pix_on_reg, pix_on_next;

    logic              active_reg, active_next;
    lpfr_pkg::phase_t  phase_reg, phase_next;
    logic [2:0]        cur_page_reg, cur_page_next;
    logic [2:0]        end_page_reg, end_page_next;
    logic [6:0]        cur_col_reg, cur_col_next;
    logic [6:0]        start_col_reg, start_col_next;
    logic [6:0]        end_col_reg, end_col_next;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;
    logic       m_tlast_reg;

    logic       out_free;
    logic       out_load;
    logic [7:0] out_byte;
    logic       out_is_data;
    logic       out_last;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [2:0] page,
                                                     input logic [6:0] col);
        store_addr = ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    assign out_free  = !m_tvalid_reg || m_tready;
    assign init_busy = (state_reg == ST_SWEEP);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_val_next  = sweep_val_reg;
        pix_addr_next   = pix_addr_reg;
        pix_mask_next   = pix_mask_reg;
        pix_on_next     = pix_on_reg;
        active_next     = active_reg;
        phase_next      = phase_reg;
        cur_page_next   = cur_page_reg;
        end_page_next   = end_page_reg;
        cur_col_next    = cur_col_reg;
        start_col_next  = start_col_reg;
        end_col_next    = end_col_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = sweep_val_reg;
        mem_re          = 1'b0;
        mem_raddr       = store_addr(cur_page_reg, cur_col_reg);
        out_load        = 1'b0;
        out_byte        = rd_data_reg;
        out_is_data     = 1'b0;
        out_last        = 1'b0;

        case (state_reg)
            ST_SWEEP: begin
                mem_we = 1'b1;
                if (sweep_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                if (head_valid) begin
                    case (head_cmd.op)
                        lpfr_pkg::OP_PIXEL: begin
                            pop = 1'b1;
                            if (head_cmd.hit) begin
                                mem_re        = 1'b1;
                                mem_raddr     = store_addr(head_cmd.page, head_cmd.col);
                                pix_addr_next = store_addr(head_cmd.page, head_cmd.col);
                                pix_mask_next = 8'd1 << head_cmd.bit_sel;
                                pix_on_next   = head_cmd.pixel_on;
                                state_next    = ST_RMW;
                            end
                        end
                        lpfr_pkg::OP_FILL: begin
                            pop             = 1'b1;
                            sweep_val_next  = head_cmd.fill;
                            sweep_addr_next = '0;
                            state_next      = ST_SWEEP;
                        end
                        lpfr_pkg::OP_REFRESH: begin
                            pop         = 1'b1;
                            phase_next  = lpfr_pkg::PH_PAGE;
                            active_next = head_cmd.area_ok;
                            if (head_cmd.area_ok) begin
                                cur_page_next  = head_cmd.page;
                                end_page_next  = head_cmd.end_page;
                                start_col_next = head_cmd.col;
                                end_col_next   = head_cmd.end_col;
                                cur_col_next   = head_cmd.col;
                            end
                        end
                        lpfr_pkg::OP_TICK: begin
                            if (!active_reg) begin
                                pop = 1'b1;
                            end else begin
                                case (phase_reg)
                                    lpfr_pkg::PH_PAGE: begin
                                        if (out_free) begin
                                            pop        = 1'b1;
                                            out_load   = 1'b1;
                                            out_byte   = lpfr_pkg::CMD_PAGE | {5'd0, cur_page_reg};
                                            phase_next = lpfr_pkg::PH_COL_HIGH;
                                        end
                                    end
                                    lpfr_pkg::PH_COL_HIGH: begin
                                        if (out_free) begin
                                            pop        = 1'b1;
                                            out_load   = 1'b1;
                                            out_byte   = lpfr_pkg::CMD_COL_HIGH
                                                       | {4'd0, 4'(start_col_reg >> 4)
                                                                & lpfr_pkg::NIBBLE_MASK};
                                            phase_next = lpfr_pkg::PH_COL_LOW;
                                        end
                                    end
                                    lpfr_pkg::PH_COL_LOW: begin
                                        if (out_free) begin
                                            pop      = 1'b1;
                                            out_load = 1'b1;
                                            out_byte = lpfr_pkg::CMD_COL_LOW
                                                     | {4'd0, start_col_reg[3:0]
                                                              & lpfr_pkg::NIBBLE_MASK};
                                            if (end_col_reg >= start_col_reg) begin
                                                cur_col_next = start_col_reg;
                                                phase_next   = lpfr_pkg::PH_DATA;
                                            end else begin
                                                // empty column range: page ends here
                                                phase_next = lpfr_pkg::PH_PAGE;
                                                if (cur_page_reg == end_page_reg) begin
                                                    out_last    = 1'b1;
                                                    active_next = 1'b0;
                                                end else begin
                                                    cur_page_next = cur_page_reg + 1'b1;
                                                end
                                            end
                                        end
                                    end
                                    lpfr_pkg::PH_DATA: begin
                                        // fetch the column byte; ST_DATA emits it once the output register is free
                                        pop        = 1'b1;
                                        mem_re     = 1'b1;
                                        state_next = ST_DATA;
                                    end
                                    default: begin
                                        phase_next = lpfr_pkg::PH_PAGE;
                                    end
                                endcase
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end

            ST_RMW: begin
                mem_we     = 1'b1;
                mem_waddr  = pix_addr_reg;
                mem_wdata  = pix_on_reg ? (rd_data_reg | pix_mask_reg)
                                        : (rd_data_reg & ~pix_mask_reg);
                state_next = ST_IDLE;
            end

            ST_DATA: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_is_data = 1'b1;
                    state_next  = ST_IDLE;
                    if (cur_col_reg >= end_col_reg) begin
                        phase_next = lpfr_pkg::PH_PAGE;
                        if (cur_page_reg == end_page_reg) begin
                            out_last    = 1'b1;
                            active_next = 1'b0;
                        end else begin
                            cur_page_next = cur_page_reg + 1'b1;
                        end
                    end else begin
                        cur_col_next = cur_col_reg + 1'b1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word register
    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            sweep_val_reg  <= '0;
            active_reg     <= 1'b0;
            phase_reg      <= lpfr_pkg::PH_PAGE;
            cur_page_reg   <= '0;
            end_page_reg   <= '0;
            cur_col_reg    <= '0;
            start_col_reg  <= '0;
            end_col_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_val_reg  <= sweep_val_next;
            active_reg     <= active_next;
            phase_reg      <= phase_next;
            cur_page_reg   <= cur_page_next;
            end_page_reg   <= end_page_next;
            cur_col_reg    <= cur_col_next;
            start_col_reg  <= start_col_next;
            end_col_reg    <= end_col_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pix_addr_reg <= pix_addr_next;
        pix_mask_reg <= pix_mask_next;
        pix_on_reg   <= pix_on_next;
        if (out_load) begin
            m_tdata_reg <= out_byte;
            m_tuser_reg <= out_is_data;
            m_tlast_reg <= out_last;
        end
    end

    // Frame store memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == ST_IDLE))
        else $error("queue popped outside idle");

    a_data_needs_refresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DATA) |-> active_reg)
        else $error("data fetch without pending refresh");

    a_page_order: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (cur_page_reg <= end_page_reg))
        else $error("current page passed end page");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output word overwritten");

endmodule

`default_nettype wire

@@ sv/lcd_page_framebuffer_refresh.sv @@
// A command byte enters the output register when its tick leaves the queue; a data byte
// is first read from the frame store, then loaded in ST_DATA. Command-byte, refresh and
// idle ticks need only the idle state; data-byte ticks and pixel writes also pass ST_DATA
// or ST_RMW (frame store read port, then write or output) before the next command.
// Fill writes one frame store entry per cycle. Reset: aresetn low clears control, then a
// clearing pass zeroes all COLUMNS*PAGES entries, with s_tready held low until it ends.
// ----------------------------------------------------------------------------
// lcd_page_framebuffer_refresh: page-organized monochrome LCD frame store
// Stream front end feeds a short command queue; the execution unit keeps
// the frame store and streams page/column commands and data bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_page_framebuffer_refresh #(
    parameter int COLUMNS = lpfr_pkg::COLUMNS_DEFAULT,
    parameter int PAGES   = lpfr_pkg::PAGES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x[6:0], y[12:7], pixel_on[13], fill_value[21:14], x_end[28:22],
    // y_end[34:29], zero[39:35]
    input  wire logic [39:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // byte_value[7:0]
    output logic [7:0]       m_tdata,
    // is_data[0]
    output logic             m_tuser,
    output logic             m_tlast
);

    logic           queue_full;
    logic           init_busy;
    logic           push;
    lpfr_pkg::cmd_t push_cmd;
    logic           head_valid;
    lpfr_pkg::cmd_t head_cmd;
    logic           pop;

    lpfr_front #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    lpfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    lpfr_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .init_busy  (init_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

@@ tb/tb_lcd_page_framebuffer_refresh.sv @@
// ----------------------------------------------------------------------------
// tb_lcd_page_framebuffer_refresh: self-checking bench for the page LCD store
// A shadow frame store and refresh sequencer predict every panel byte from
// the accepted command words. Directed corner words come first, then
// randomized area refreshes with tick runs, pixel writes and fills, under
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lcd_page_framebuffer_refresh;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int STORE_WORDS = lpfr_pkg::COLUMNS_DEFAULT * lpfr_pkg::PAGES_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int WORD_TARGET = 1050;
    localparam int DRAIN_WAIT  = 64;

    // One stimulus word; a pause entry holds the sender until results drain
    typedef struct {
        bit                pause;
        lpfr_pkg::op_t     op;
        logic [6:0]        x;
        logic [5:0]        y;
        logic              on;
        logic [7:0]        fill;
        logic [6:0]        xe;
        logic [5:0]        ye;
    } stim_t;

    // One predicted panel byte
    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       last;
    } panel_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = lpfr_pkg::OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Stimulus and expectation stores
    stim_t       pend_q[$];
    panel_byte_t panel_q[$];
    int          words_pushed = 0;
    int          words_taken  = 0;
    int          fail_cnt     = 0;
    int          cycle_cnt    = 0;

    // Handshake bookkeeping shared between edges
    bit          word_taken = 1'b0;
    int          send_gap   = 0;
    int          rcv_stall  = 0;
    bit          send_lazy  = 1'b1;
    bit          rcv_lazy   = 1'b1;
    stim_t       drv_word;

    // Shadow frame store and refresh sequencer
    logic [7:0]        fb_mem [STORE_WORDS];
    logic              rf_busy      = 1'b0;
    logic [2:0]        rf_page      = '0;
    logic [2:0]        rf_end_page  = '0;
    lpfr_pkg::phase_t  rf_phase     = lpfr_pkg::PH_PAGE;
    logic [6:0]        rf_col       = '0;
    logic [6:0]        rf_start_col = '0;
    logic [6:0]        rf_end_col   = '0;

    lcd_page_framebuffer_refresh dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Close out one page of the refresh; returns 1 when the area is done
    function automatic logic page_finish();
        rf_phase = lpfr_pkg::PH_PAGE;
        if (rf_page == rf_end_page) begin
            rf_busy = 1'b0;
            return 1'b1;
        end
        rf_page = rf_page + 3'd1;
        return 1'b0;
    endfunction

    // Apply one accepted word to the shadow state, queue any panel byte
    task automatic frame_step(input lpfr_pkg::op_t op, input logic [6:0] x,
                              input logic [5:0] y, input logic on, input logic [7:0] fill,
                              input logic [6:0] xe, input logic [5:0] ye);
        logic [2:0]  p0;
        logic [2:0]  p1;
        panel_byte_t pb;
        case (op)
            lpfr_pkg::OP_PIXEL: begin
                fb_mem[{y[5:3], x}][y[2:0]] = on;
            end
            lpfr_pkg::OP_FILL: begin
                for (int i = 0; i < STORE_WORDS; i++) fb_mem[i] = fill;
            end
            lpfr_pkg::OP_REFRESH: begin
                p0 = y[5:3];
                p1 = ye[5:3];
                rf_phase = lpfr_pkg::PH_PAGE;
                if (p1 < p0) begin
                    rf_busy = 1'b0;
                end else begin
                    rf_busy      = 1'b1;
                    rf_page      = p0;
                    rf_end_page  = p1;
                    rf_start_col = x;
                    rf_end_col   = xe;
                    rf_col       = x;
                end
            end
            default: begin
                if (rf_busy) begin
                    pb = '0;
                    case (rf_phase)
                        lpfr_pkg::PH_PAGE: begin
                            pb.value = lpfr_pkg::CMD_PAGE | {5'd0, rf_page};
                            rf_phase = lpfr_pkg::PH_COL_HIGH;
                        end
                        lpfr_pkg::PH_COL_HIGH: begin
                            pb.value = lpfr_pkg::CMD_COL_HIGH | {5'd0, rf_start_col[6:4]};
                            rf_phase = lpfr_pkg::PH_COL_LOW;
                        end
                        lpfr_pkg::PH_COL_LOW: begin
                            pb.value = lpfr_pkg::CMD_COL_LOW
                                     | {4'd0, rf_start_col[3:0] & lpfr_pkg::NIBBLE_MASK};
                            if (rf_end_col >= rf_start_col) begin
                                rf_col   = rf_start_col;
                                rf_phase = lpfr_pkg::PH_DATA;
                            end else begin
                                pb.last = page_finish();
                            end
                        end
                        default: begin
                            pb.value   = fb_mem[{rf_page, rf_col}];
                            pb.is_data = 1'b1;
                            if (rf_col >= rf_end_col)
                                pb.last = page_finish();
                            else
                                rf_col = rf_col + 7'd1;
                        end
                    endcase
                    panel_q.push_back(pb);
                end
            end
        endcase
    endtask

    // Panel bytes a complete refresh of an area takes
    function automatic int area_bytes(int ax, int ay, int axe, int aye);
        int pages;
        pages = aye / 8 - ay / 8 + 1;
        if (pages <= 0) return 0;
        return pages * (3 + ((axe >= ax) ? axe - ax + 1 : 0));
    endfunction

    function automatic int cap(int v, int hi);
        return (v > hi) ? hi : v;
    endfunction

    function automatic stim_t rand_word(lpfr_pkg::op_t op);
        stim_t w;
        w.pause = 1'b0;
        w.op    = op;
        w.x     = 7'($urandom_range(0, 127));
        w.y     = 6'($urandom_range(0, 63));
        w.on    = 1'($urandom_range(0, 1));
        w.fill  = 8'($urandom_range(0, 255));
        w.xe    = 7'($urandom_range(0, 127));
        w.ye    = 6'($urandom_range(0, 63));
        return w;
    endfunction

    task automatic add_word(input stim_t w);
        pend_q.push_back(w);
        if (!w.pause) words_pushed++;
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_word(rand_word(lpfr_pkg::OP_TICK));
    endtask

    task automatic add_area(input int ax, input int ay, input int axe, input int aye);
        stim_t w;
        w    = rand_word(lpfr_pkg::OP_REFRESH);
        w.x  = 7'(ax);
        w.y  = 6'(ay);
        w.xe = 7'(axe);
        w.ye = 6'(aye);
        add_word(w);
    endtask

    task automatic add_pixel(input int ax, input int ay, input bit on);
        stim_t w;
        w    = rand_word(lpfr_pkg::OP_PIXEL);
        w.x  = 7'(ax);
        w.y  = 6'(ay);
        w.on = on;
        add_word(w);
    endtask

    task automatic add_fill(input int v);
        stim_t w;
        w      = rand_word(lpfr_pkg::OP_FILL);
        w.fill = 8'(v);
        add_word(w);
    endtask

    task automatic add_pause();
        stim_t w;
        w       = rand_word(lpfr_pkg::OP_TICK);
        w.pause = 1'b1;
        add_word(w);
    endtask

    // Input driver: new word or idle at the falling edge
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !word_taken)) begin
            word_taken = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() != 0 && pend_q[0].pause) begin
                s_tvalid <= 1'b0;
                if (panel_q.size() == 0) void'(pend_q.pop_front());
            end else if (pend_q.size() != 0) begin
                drv_word = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_word.op;
                s_tdata  <= {5'd0, drv_word.ye, drv_word.xe, drv_word.fill,
                             drv_word.on, drv_word.y, drv_word.x};
                if ($urandom_range(0, 63) == 0) send_lazy = ~send_lazy;
                send_gap = send_lazy ? $urandom_range(0, 6) : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result back-pressure
    always @(negedge aclk) begin
        if (rcv_stall != 0) begin
            rcv_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: check panel bytes, then feed accepted words to the predictor
    always @(posedge aclk) begin
        panel_byte_t pb;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("lcd_page_framebuffer_refresh: mismatch");
            $finish;
        end
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if ($urandom_range(0, 63) == 0) rcv_lazy = ~rcv_lazy;
                rcv_stall = rcv_lazy ? $urandom_range(0, 6) : 0;
                if (panel_q.size() == 0) begin
                    $error("unexpected word: byte_value %0h is_data %0b last %0b",
                           m_tdata, m_tuser, m_tlast);
                    fail_cnt++;
                end else begin
                    pb = panel_q.pop_front();
                    if (m_tdata !== pb.value) begin
                        $error("byte_value: expected %0h, actual %0h", pb.value, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tuser !== pb.is_data) begin
                        $error("is_data: expected %0b, actual %0b", pb.is_data, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tlast !== pb.last) begin
                        $error("last_of_refresh: expected %0b, actual %0b", pb.last, m_tlast);
                        fail_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                word_taken = 1'b1;
                words_taken++;
                frame_step(lpfr_pkg::op_t'(s_tuser), s_tdata[6:0], s_tdata[12:7],
                           s_tdata[13], s_tdata[21:14], s_tdata[28:22], s_tdata[34:29]);
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int ax, ay, axe, aye, n, sel;
        bit pause_done;
        stim_t w;
        pause_done = 1'b0;
        for (int i = 0; i < STORE_WORDS; i++) fb_mem[i] = 8'd0;
        rcv_stall = $urandom_range(0, 6);

        // Directed corners
        add_ticks(1);                       // tick with nothing pending
        add_pixel(0, 0, 1'b1);
        add_pixel(127, 63, 1'b1);
        add_pixel(64, 31, 1'b1);
        add_pixel(64, 31, 1'b0);            // clear again
        add_area(127, 56, 127, 63);         // last page, last column
        add_ticks(4);
        add_area(0, 0, 0, 7);
        add_ticks(1);
        add_area(5, 0, 3, 15);              // restart with empty column range
        add_ticks(6);
        add_area(0, 40, 127, 8);            // empty page range
        add_ticks(1);
        add_fill(8'hFF);
        add_area(126, 0, 127, 0);
        add_pixel(127, 0, 1'b0);            // write lands on a byte not yet sent
        add_ticks(5);
        add_pause();

        // Largest areas, few of them
        add_fill($urandom_range(0, 255));
        ay = 8 * $urandom_range(0, 7);
        add_area(0, ay, 127, ay + 7);
        add_ticks(131);
        ax = $urandom_range(0, 127);
        add_area(ax, 0, ax, 63);
        add_ticks(32);
        add_area(0, 0, 127, 63);            // full refresh, cut short
        add_ticks(200);
        add_area(0, 63, 0, 0);              // cancels the pending refresh
        add_ticks(1);

        // Random area refreshes with tick runs, plus noise
        while (words_pushed < WORD_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                ax = $urandom_range(0, 127);
                ay = $urandom_range(0, 63);
                if ($urandom_range(0, 7) == 0)
                    axe = (ax >= 3) ? ax - $urandom_range(1, 3) : ax;
                else
                    axe = cap(ax + $urandom_range(0, 5), 127);
                if ($urandom_range(0, 7) == 0)
                    aye = (ay >= 8) ? ay - 8 : ay;
                else
                    aye = cap(ay + $urandom_range(0, 12), 63);
                n = area_bytes(ax, ay, axe, aye);
                if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
                add_area(ax, ay, axe, aye);
                repeat (n) begin
                    if ($urandom_range(0, 11) == 0)
                        add_pixel(cap(ax + $urandom_range(0, 5), 127),
                                  $urandom_range(0, 63), 1'($urandom_range(0, 1)));
                    add_ticks(1);
                end
                if ($urandom_range(0, 7) == 0) add_ticks($urandom_range(1, 3));
            end else if (sel < 67) begin
                add_fill($urandom_range(0, 255));
            end else begin
                w = rand_word(lpfr_pkg::op_t'($urandom_range(0, 3)));
                if (w.op == lpfr_pkg::OP_FILL) w.op = lpfr_pkg::OP_TICK;
                add_word(w);
            end
            if (!pause_done && words_pushed > 600) begin
                add_pause();
                pause_done = 1'b1;
            end
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (words_taken != words_pushed || panel_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (fail_cnt == 0 && panel_q.size() == 0) begin
            $display("lcd_page_framebuffer_refresh: match");
        end else begin
            $display("lcd_page_framebuffer_refresh: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
sv/lpfr_pkg.sv
sv/lpfr_front.sv
sv/lpfr_queue.sv
sv/lpfr_back.sv
sv/lcd_page_framebuffer_refresh.sv
tb/tb_lcd_page_framebuffer_refresh.sv
